[sv/sik_pkg.sv]
// shared types, constants and the cordic angle table for the scara inverse kinematics block
// no dependencies
package sik_pkg;

  // arm geometry and polynomial coefficients
  localparam int C_RAD0 = -66015625;
  localparam int C_RAD1 = 106250;
  localparam int C_OFF1 = 8125;
  localparam int C_ARM = 300;
  localparam int C_OFF2 = 625;
  localparam int C_LIFT = 25;
  localparam int C_FULL = 360;
  localparam int C_HALF_TURN = 180;
  localparam int C_QUARTER = 90;

  // configuration register indexes
  localparam logic CFG_MAX_RADIUS = 1'b0;
  localparam logic CFG_MIN_RADIUS = 1'b1;

  // atan(2^-i) in units of 1e-10 degree
  localparam int ATAN_TAB_LEN = 28;
  localparam longint unsigned ATAN_UNIT = 64'd10000000000;
  localparam longint unsigned ATAN_TAB [ATAN_TAB_LEN] = '{
    64'd450000000000, 64'd265650511771, 64'd140362434679, 64'd71250163489,
    64'd35763343750, 64'd17899106082, 64'd8951737102, 64'd4476141709,
    64'd2238105004, 64'd1119056771, 64'd559528919, 64'd279764526,
    64'd139882271, 64'd69941137, 64'd34970569, 64'd17485284,
    64'd8742642, 64'd4371321, 64'd2185661, 64'd1092830,
    64'd546415, 64'd273208, 64'd136604, 64'd68302,
    64'd34151, 64'd17075, 64'd8538, 64'd4269
  };

  // control carried alongside each operand pair through the cordic row
  typedef struct packed {
    logic vld;
    logic zero;
  } sik_tag_t;

  // step angle scaled to frac fraction bits, rounded to nearest
  function automatic longint unsigned step_angle(int i, int frac);
    longint unsigned a;
    a = ATAN_TAB[i % ATAN_TAB_LEN];
    return ((a << frac) + ATAN_UNIT / 2) / ATAN_UNIT;
  endfunction

endpackage

[sv/sik_sqrt.sv]
// iterative integer square root, one result bit per cycle
// depends on sik_pkg
module sik_sqrt import sik_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [33:0]             rad_i,
  output logic                    done_o,
  output logic [17+FRAC_BITS-1:0] root_o
);
  localparam int NIT = 17 + FRAC_BITS;
  localparam int RW = NIT;
  localparam int SW = 2 * NIT;
  localparam int CW = $clog2(NIT + 1);

  logic [SW-1:0] sr_q, sr_d;
  logic [RW+1:0] rem_q, rem_d, rem_sh, trial;
  logic [RW-1:0] root_q, root_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  // one restoring step per cycle
  always_comb begin
    sr_d = sr_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RW-1:0], sr_q[SW-1:SW-2]};
    trial = {root_q, 2'b01};
    if (start_i) begin
      sr_d = {rad_i, {(2 * FRAC_BITS){1'b0}}};
      rem_d = '0;
      root_d = '0;
      cnt_d = CW'(NIT);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sr_d = {sr_q[SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[sv/sik_cordic_cell.sv]
// one vectoring cordic micro-rotation, registered
// depends on sik_pkg
module sik_cordic_cell import sik_pkg::*; #(
  parameter int STEP = 0,
  parameter int FRAC_BITS = 16,
  parameter int W = 39,
  parameter int ZW = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sik_tag_t             tag_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output sik_tag_t             tag_o,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);
  localparam logic signed [ZW-1:0] ANG = ZW'(step_angle(STEP, FRAC_BITS));

  sik_tag_t             tag_q;
  logic signed [W-1:0]  x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk_i) begin
    if (!y_i[W-1]) begin
      x_q <= x_i + dx;
      y_q <= y_i - dy;
      z_q <= z_i + ANG;
    end else begin
      x_q <= x_i - dx;
      y_q <= y_i + dy;
      z_q <= z_i - ANG;
    end
  end

  assign tag_o = tag_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[sv/sik_cordic_chain.sv]
// atan2 in degrees: quadrant pre-rotation stage then a row of cordic cells
// depends on sik_pkg, sik_cordic_cell
module sik_cordic_chain import sik_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 18,
  parameter int W = 39,
  parameter int ZW = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sik_tag_t             tag_i,
  input  logic signed [W-1:0]  num_i,
  input  logic signed [W-1:0]  den_i,
  output sik_tag_t             tag_o,
  output logic signed [ZW-1:0] ang_o
);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(C_QUARTER) <<< FRAC_BITS;
  localparam int NCELL = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;

  sik_tag_t             tag_s [NCELL+1];
  logic signed [W-1:0]  x_s [NCELL+1];
  logic signed [W-1:0]  y_s [NCELL+1];
  logic signed [ZW-1:0] z_s [NCELL+1];

  sik_tag_t tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q.vld <= tag_i.vld;
      tag_q.zero <= (num_i == '0) && (den_i == '0);
    end
  end

  // pre-rotate by a quarter turn when the x operand is negative
  logic signed [W-1:0]  px_q, py_q;
  logic signed [ZW-1:0] pz_q;
  always_ff @(posedge clk_i) begin
    if (den_i[W-1]) begin
      if (!num_i[W-1]) begin
        px_q <= num_i;
        py_q <= -den_i;
        pz_q <= QUARTER;
      end else begin
        px_q <= -num_i;
        py_q <= den_i;
        pz_q <= -QUARTER;
      end
    end else begin
      px_q <= den_i;
      py_q <= num_i;
      pz_q <= '0;
    end
  end

  assign tag_s[0] = tag_q;
  assign x_s[0] = px_q;
  assign y_s[0] = py_q;
  assign z_s[0] = pz_q;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    sik_cordic_cell #(
      .STEP(i), .FRAC_BITS(FRAC_BITS), .W(W), .ZW(ZW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tag_i (tag_s[i]),
      .x_i   (x_s[i]),
      .y_i   (y_s[i]),
      .z_i   (z_s[i]),
      .tag_o (tag_s[i+1]),
      .x_o   (x_s[i+1]),
      .y_o   (y_s[i+1]),
      .z_o   (z_s[i+1])
    );
  end

  assign tag_o = tag_s[NCELL];
  assign ang_o = z_s[NCELL];

endmodule

[sv/scara_inverse_kinematics.sv]
// top level of the scara inverse kinematics block: handshakes, polynomials, sequencing
// depends on sik_pkg, sik_sqrt, sik_cordic_chain
//
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tdata x,y,z,yaw; tuser elbow_select
// m_axis    out        m_axis_tvalid/tready       tdata shoulder,elbow,lift,wrist; tuser reachable
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// an in-band item is held first by the bit-serial square root, then while its two operand
// pairs feed and drain the cordic row, before its result is loaded; an out-of-band item
// skips the square root and the cordic row
// one item is in work at a time
// the result sits in an output register, so the next beat is taken while it waits;
// a stalled receiver holds the sequencer in its last state until the register frees up
// reset restores max_radius 325, min_radius 25 and held angles of zero
module scara_inverse_kinematics import sik_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // x_pos[9:0], y_pos[19:10], z_pos[27:20], yaw_deg[36:28]
  input  logic        s_axis_tuser,  // elbow_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // shoulder[8:0], elbow[17:9], lift[26:18], wrist[37:27]
  output logic        m_axis_tuser,  // reachable
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  localparam int W = 23 + FRAC_BITS;
  localparam int ZW = 10 + FRAC_BITS;
  localparam int TW = ZW + 2;
  localparam int RW = 17 + FRAC_BITS;
  localparam int QW = 11;
  localparam logic [TW-1:0] HALF = TW'(1) << (FRAC_BITS - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ    = 10'b0000000010,
    S_POLY  = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_OPS   = 10'b0000010000,
    S_FEED0 = 10'b0000100000,
    S_FEED1 = 10'b0001000000,
    S_WAIT  = 10'b0010000000,
    S_RND   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } sik_state_e;

  sik_state_e st_q, st_d;

  // configuration registers
  logic [8:0] max_q, min_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 9'd325;
      min_q <= 9'd25;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_RADIUS: max_q <= cfg_data_i;
        CFG_MIN_RADIUS: min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input capture
  logic signed [9:0] x_q, y_q;
  logic [7:0]        z_q;
  logic signed [8:0] yaw_q;
  logic              sel_q;
  logic              in_acc;
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= s_axis_tdata[9:0];
      y_q <= s_axis_tdata[19:10];
      z_q <= s_axis_tdata[27:20];
      yaw_q <= s_axis_tdata[36:28];
      sel_q <= s_axis_tuser;
    end
  end

  // squared radius and band limits
  logic [19:0] r2_q, mx2_q, mn2_q;
  logic signed [20:0] xe, ye;
  assign xe = 21'(x_q);
  assign ye = 21'(y_q);
  always_ff @(posedge clk_i) begin
    if (st_q == S_SQ) begin
      r2_q <= 20'(xe * xe + ye * ye);
      mx2_q <= 20'(max_q * max_q);
      mn2_q <= 20'(min_q * min_q);
    end
  end

  // radicand, clamped at zero
  logic [39:0]        r2sq;
  logic [36:0]        r2k;
  logic signed [41:0] rad;
  logic [33:0]        rad_cl;
  logic               reach_d, reach_q;
  assign r2sq = r2_q * r2_q;
  assign r2k = 37'(r2_q) * 37'(C_RAD1);
  assign rad = 42'(C_RAD0) + $signed({5'b0, r2k}) - $signed({2'b0, r2sq});
  assign rad_cl = rad[41] ? '0 : rad[33:0];
  assign reach_d = (r2_q <= mx2_q) && (r2_q > mn2_q);
  always_ff @(posedge clk_i) begin
    if (st_q == S_POLY) begin
      reach_q <= reach_d;
    end
  end

  logic          sq_done;
  logic [RW-1:0] root;
  sik_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i((st_q == S_POLY) && reach_d),
    .rad_i  (rad_cl),
    .done_o (sq_done),
    .root_o (root)
  );

  // atan2 operands
  logic signed [W-1:0] n1_q, d1_q, d2_q, rootw, ys300;
  assign rootw = W'($signed({1'b0, root}));
  assign ys300 = (W'(y_q) * W'(C_ARM)) <<< FRAC_BITS;
  always_ff @(posedge clk_i) begin
    if (st_q == S_OPS) begin
      n1_q <= sel_q ? (ys300 + rootw) : (ys300 - rootw);
      d1_q <= (W'($signed({1'b0, r2_q})) + W'(x_q) * W'(C_ARM) - W'(C_OFF1)) <<< FRAC_BITS;
      d2_q <= (W'($signed({1'b0, r2_q})) - W'(C_OFF2)) <<< FRAC_BITS;
    end
  end

  sik_tag_t            ch_tag_in, ch_tag_out;
  logic signed [W-1:0] ch_num, ch_den;
  logic signed [ZW-1:0] ch_ang;
  always_comb begin
    ch_tag_in = '0;
    ch_num = n1_q;
    ch_den = d1_q;
    if (st_q == S_FEED0) begin
      ch_tag_in.vld = 1'b1;
    end else if (st_q == S_FEED1) begin
      ch_tag_in.vld = 1'b1;
      ch_num = rootw;
      ch_den = d2_q;
    end
  end

  sik_cordic_chain #(
    .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .W(W), .ZW(ZW)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (ch_tag_in),
    .num_i (ch_num),
    .den_i (ch_den),
    .tag_o (ch_tag_out),
    .ang_o (ch_ang)
  );

  // collect the two angles in order: shoulder first
  logic                 got_q;
  logic signed [ZW-1:0] sh_raw_q, el_raw_q, ang_fix;
  assign ang_fix = ch_tag_out.zero ? '0 : ch_ang;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      got_q <= 1'b0;
    end else if (ch_tag_out.vld) begin
      got_q <= !got_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ch_tag_out.vld) begin
      if (!got_q) begin
        sh_raw_q <= ang_fix;
      end else begin
        el_raw_q <= ang_fix;
      end
    end
  end

  // double, round half away from zero, wrap once into -180..180
  function automatic logic signed [8:0] rnd_wrap(logic signed [ZW-1:0] th, logic neg);
    logic signed [TW-1:0] t, ta;
    logic signed [QW-1:0] qa, q;
    t = TW'(th) <<< 1;
    if (neg) t = -t;
    ta = t[TW-1] ? -t : t;
    qa = QW'((ta + $signed(HALF)) >>> FRAC_BITS);
    q = t[TW-1] ? -qa : qa;
    if (q > QW'(C_HALF_TURN)) q = q - QW'(C_FULL);
    if (q < -QW'(C_HALF_TURN)) q = q + QW'(C_FULL);
    return q[8:0];
  endfunction

  logic signed [8:0] sh_q, el_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q <= '0;
      el_q <= '0;
    end else if (st_q == S_RND) begin
      sh_q <= rnd_wrap(sh_raw_q, 1'b0);
      el_q <= rnd_wrap(el_raw_q, sel_q);
    end
  end

  // output register
  logic        m_vld_q, out_load;
  logic [39:0] m_data_q;
  logic        m_user_q;
  logic signed [8:0]  lift;
  logic signed [10:0] wrist;
  assign lift = $signed({1'b0, z_q}) - 9'(C_LIFT);
  assign wrist = 11'(yaw_q) - 11'(sh_q) - 11'(el_q);
  assign out_load = (st_q == S_DONE) && (!m_vld_q || m_axis_tready);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_load) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {2'b00, wrist, lift, el_q, sh_q};
      m_user_q <= reach_q;
    end
  end
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata = m_data_q;
  assign m_axis_tuser = m_user_q;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (in_acc) st_d = S_SQ;
      S_SQ:    st_d = S_POLY;
      S_POLY:  st_d = reach_d ? S_SQRT : S_DONE;
      S_SQRT:  if (sq_done) st_d = S_OPS;
      S_OPS:   st_d = S_FEED0;
      S_FEED0: st_d = S_FEED1;
      S_FEED1: st_d = S_WAIT;
      S_WAIT:  if (ch_tag_out.vld && got_q) st_d = S_RND;
      S_RND:   st_d = S_DONE;
      S_DONE:  if (out_load) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // the cordic row drains before a new beat is taken
  a_chain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !ch_tag_out.vld) else $error("cordic result outside wait");

  // cordic results only arrive while waiting for them
  a_chain_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_tag_out.vld |-> (st_q == S_WAIT)) else $error("unexpected cordic result");

  // square root finishes only while the sequencer waits on it
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (st_q == S_SQRT)) else $error("square root done out of sequence");

  // out-of-band items leave the held angles untouched
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE) && !reach_q |=> $stable(sh_q) && $stable(el_q))
    else $error("held angles changed");

endmodule

[bench/tb.sv]
// self-checking testbench for scara_inverse_kinematics: directed table, then random phases
// depends on sik_pkg and the rtl of the block; uses its own fixed-point joint predictor
module tb;
  import sik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int STEPS = 18;
  localparam int PHASE_ITEMS = 90;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [8:0]  shoulder;
    logic signed [8:0]  elbow;
    logic signed [8:0]  lift;
    logic signed [10:0] wrist;
    logic               reach;
  } joints_t;

  typedef struct {
    int      x;
    int      y;
    int      z;
    int      yaw;
    bit      sel;
    bit      typed;
    joints_t want;
  } target_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_MAX_RADIUS;
  logic [8:0]  cfg_data_i = '0;

  scara_inverse_kinematics uut (.*);

  // predictor state
  int     reach_max = 325;
  int     reach_min = 25;
  int     hold_sh = 0;
  int     hold_el = 0;
  longint step_deg [STEPS];

  joints_t pending_joints [$];
  int      mismatches = 0;
  int      beats_in = 0;
  int      beats_out = 0;
  int      reached = 0;
  int      sender_idle_pct = 0;
  int      receiver_idle_pct = 0;
  int      holdoff_cycles = 0;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned isqrt_frac(longint unsigned rad);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int k = 16 + FB; k >= 0; k--) begin
      pair = (k >= FB) ? ((rad >> (2 * (k - FB))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint yy, longint xx);
    longint z, t, dx, dy;
    z = 0;
    if (xx == 0 && yy == 0) return 0;
    // fold the left half plane by a quarter turn
    if (xx < 0) begin
      t = xx;
      if (yy >= 0) begin
        xx = yy; yy = -t; z = 90 * (longint'(1) << FB);
      end else begin
        xx = -yy; yy = t; z = -90 * (longint'(1) << FB);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (yy >= 0) begin
        xx += dx; yy -= dy; z += step_deg[i];
      end else begin
        xx -= dx; yy += dy; z -= step_deg[i];
      end
    end
    return z;
  endfunction

  function automatic int whole_degrees(longint theta, bit negate);
    longint t, q;
    t = negate ? -2 * theta : 2 * theta;
    if (t >= 0) q = (t + (longint'(1) << (FB - 1))) >>> FB;
    else q = -((-t + (longint'(1) << (FB - 1))) >>> FB);
    if (q > 180) q -= 360;
    if (q < -180) q += 360;
    return int'(q);
  endfunction

  // joint angles for one target, updating the held angles
  function automatic joints_t solve_joints(int x, int y, int z, int yaw, bit sel);
    joints_t j;
    longint r2, rad, root, n1, d1, d2, one;
    bit ok;
    one = longint'(1) << FB;
    r2 = longint'(x) * x + longint'(y) * y;
    ok = (r2 <= longint'(reach_max) * reach_max) && (r2 > longint'(reach_min) * reach_min);
    if (ok) begin
      rad = -66015625 + 106250 * r2 - r2 * r2;
      if (rad < 0) rad = 0;
      root = longint'(isqrt_frac(rad));
      n1 = 300 * longint'(y) * one + (sel ? root : -root);
      d1 = (r2 + 300 * x - 8125) * one;
      d2 = (r2 - 625) * one;
      hold_sh = whole_degrees(vector_angle(n1, d1), 1'b0);
      hold_el = whole_degrees(vector_angle(root, d2), sel);
    end
    j.shoulder = hold_sh[8:0];
    j.elbow = hold_el[8:0];
    j.lift = 9'(z - 25);
    j.wrist = 11'(yaw - hold_sh - hold_el);
    j.reach = ok;
    return j;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, beats_out, got, want);
    mismatches++;
  endtask

  // one target beat, with optional idle cycles ahead of it
  task automatic send_target(int x, int y, int z, int yaw, bit sel, bit typed, joints_t want);
    joints_t j;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, 9'(yaw), 8'(z), 10'(y), 10'(x)};
    s_axis_tuser <= sel;
    do @(posedge clk_i); while (!s_axis_tready);
    j = solve_joints(x, y, z, yaw, sel);
    if (typed) j = want;
    pending_joints.insert(pending_joints.size(), j);
    beats_in++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 9'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAX_RADIUS) reach_max = value;
    else reach_min = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_joints.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // receiver side: random stalls plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    joints_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_joints.size() == 0) begin
        $display("unexpected result beat %0d", beats_out);
        mismatches++;
      end else begin
        w = pending_joints.pop_front();
        if ($signed(m_axis_tdata[8:0]) != w.shoulder)
          report_mismatch("shoulder", $signed(m_axis_tdata[8:0]), w.shoulder);
        if ($signed(m_axis_tdata[17:9]) != w.elbow)
          report_mismatch("elbow", $signed(m_axis_tdata[17:9]), w.elbow);
        if ($signed(m_axis_tdata[26:18]) != w.lift)
          report_mismatch("lift", $signed(m_axis_tdata[26:18]), w.lift);
        if ($signed(m_axis_tdata[37:27]) != w.wrist)
          report_mismatch("wrist", $signed(m_axis_tdata[37:27]), w.wrist);
        if (m_axis_tuser != w.reach)
          report_mismatch("reachable", m_axis_tuser, w.reach);
        if (m_axis_tuser) reached++;
      end
      beats_out++;
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("[scara_inverse_kinematics] ERROR");
    $finish;
  end

  initial begin
    target_row_t rows [] = '{
      // unreachable rows with the held angles still at zero
      '{0, 0, 0, -180, 0, 1, '{0, 0, -25, -180, 0}},
      '{3, 4, 100, 90, 1, 1, '{0, 0, 75, 90, 0}},
      '{-512, -512, 255, 255, 1, 1, '{0, 0, 230, 255, 0}},
      '{511, 511, 0, -256, 0, 1, '{0, 0, -25, -256, 0}},
      // band edges, axes and the first three quadrants
      '{325, 0, 200, 180, 1, 0, '{0, 0, 0, 0, 0}},
      '{-325, 0, 0, -180, 0, 0, '{0, 0, 0, 0, 0}},
      '{0, 325, 50, 0, 1, 0, '{0, 0, 0, 0, 0}},
      '{0, -325, 50, 0, 0, 0, '{0, 0, 0, 0, 0}},
      '{26, 0, 25, 45, 1, 0, '{0, 0, 0, 0, 0}},
      '{0, -26, 25, -45, 0, 0, '{0, 0, 0, 0, 0}},
      '{25, 0, 10, 10, 1, 0, '{0, 0, 0, 0, 0}},
      '{200, 100, 120, 30, 0, 0, '{0, 0, 0, 0, 0}},
      '{-100, -200, 120, -30, 1, 0, '{0, 0, 0, 0, 0}},
      '{-150, 0, 80, 170, 1, 0, '{0, 0, 0, 0, 0}},
      '{-150, 0, 80, 170, 0, 0, '{0, 0, 0, 0, 0}},
      '{175, 150, 60, -90, 1, 0, '{0, 0, 0, 0, 0}},
      '{-1, 0, 1, 1, 0, 0, '{0, 0, 0, 0, 0}},
      '{-230, 229, 199, -179, 0, 0, '{0, 0, 0, 0, 0}}
    };
    int band_max [] = '{325, 511, 0, 325, 200, 100, 325};
    int band_min [] = '{25, 0, 0, 325, 100, 200, 25};
    int x, y, yaw;

    for (int i = 0; i < STEPS; i++)
      step_deg[i] = longint'(((ATAN_TAB[i] << FB) + ATAN_UNIT / 2) / ATAN_UNIT);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table at reset settings
    sender_idle_pct = 30;
    receiver_idle_pct = 51;
    foreach (rows[r])
      send_target(rows[r].x, rows[r].y, rows[r].z, rows[r].yaw, rows[r].sel,
                  rows[r].typed, rows[r].want);
    drain_results();

    // random phases, one band setting each
    foreach (band_max[p]) begin
      write_reg(CFG_MAX_RADIUS, band_max[p]);
      write_reg(CFG_MIN_RADIUS, band_min[p]);
      if (p < 2) begin
        sender_idle_pct = 30; receiver_idle_pct = 51;
      end else if (p < 4) begin
        sender_idle_pct = 51; receiver_idle_pct = 30;
      end else begin
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      if (p == 4) holdoff_cycles = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 75) begin
          x = $urandom_range(650) - 325;
          y = $urandom_range(650) - 325;
          yaw = $urandom_range(360) - 180;
        end else begin
          x = $signed(10'($urandom));
          y = $signed(10'($urandom));
          yaw = $signed(9'($urandom));
        end
        send_target(x, y, $urandom_range(255), yaw, $urandom_range(1), 1'b0, '{0, 0, 0, 0, 0});
      end
      drain_results();
    end

    $display("covered %0d targets over %0d band settings, %0d of %0d results reachable",
             beats_in, band_max.size() + 1, reached, beats_out);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[scara_inverse_kinematics] OK");
    end else begin
      $display("[scara_inverse_kinematics] ERROR");
    end
    $finish;
  end

endmodule
